@@ rtl/rcdiv_pkg.sv @@
// ----------------------------------------------------------------------------
// rcdiv_pkg
// Shared types and constants for the regularized complex divider.
// ----------------------------------------------------------------------------
package rcdiv_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int QUOT_WIDTH    = 32;
  localparam int EPS_WIDTH     = 32;
  localparam int CFG_IDX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH = 32;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_EPSILON    = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLAMP_MODE = 8'd1;

  localparam logic [EPS_WIDTH-1:0] EPSILON_RESET = 32'd1;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] a_re;
    logic signed [SAMPLE_WIDTH-1:0] a_im;
    logic signed [SAMPLE_WIDTH-1:0] b_re;
    logic signed [SAMPLE_WIDTH-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [QUOT_WIDTH-1:0] q_re;
    logic signed [QUOT_WIDTH-1:0] q_im;
    logic                         guarded;
    logic                         saturated;
  } out_t;

  typedef struct packed {
    logic valid;
    logic guard;
    logic neg_re;
    logic neg_im;
    logic ov_re;
    logic ov_im;
  } ctl_t;

endpackage

@@ rtl/rcdiv_front.sv @@
// ----------------------------------------------------------------------------
// rcdiv_front
// Products, numerator sums, squared magnitude, denominator select and
// overflow pre-check, over three register stages.
// ----------------------------------------------------------------------------
module rcdiv_front #(
  parameter int FRACTION_BITS = rcdiv_pkg::FRACTION_BITS,
  parameter int DW            = 33,
  parameter int CW            = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  rcdiv_pkg::in_t                     in_data,
  input  logic [rcdiv_pkg::EPS_WIDTH-1:0]    epsilon,
  input  logic                               clamp_mode,
  output rcdiv_pkg::ctl_t                    ctl,
  output logic [CW-1:0]                      num_re,
  output logic [CW-1:0]                      num_im,
  output logic [DW-1:0]                      den
);

  localparam int SW = rcdiv_pkg::SAMPLE_WIDTH;
  localparam int PW = 2 * SW;
  localparam int QW = rcdiv_pkg::QUOT_WIDTH;

  logic                 v1_r;
  logic signed [PW-1:0] p_arbr_r, p_aibi_r, p_aibr_r, p_arbi_r;
  logic        [PW-1:0] m_brbr_r, m_bibi_r;

  logic signed [PW:0]   re_sum, im_sum;
  logic        [PW:0]   re_abs, im_abs, mag2;
  logic        [DW-1:0] mag2_ext, eps_ext, den_nxt;
  logic                 below;

  logic                 v2_r, neg_re_r, neg_im_r;
  logic        [PW-1:0] mag_re_r, mag_im_r;
  logic        [DW-1:0] den2_r;

  logic        [CW-1:0] num_re_nxt, num_im_nxt, den_cw;

  rcdiv_pkg::ctl_t      ctl_r;
  logic        [CW-1:0] num_re_r, num_im_r;
  logic        [DW-1:0] den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_arbr_r <= PW'(in_data.a_re * in_data.b_re);
    p_aibi_r <= PW'(in_data.a_im * in_data.b_im);
    p_aibr_r <= PW'(in_data.a_im * in_data.b_re);
    p_arbi_r <= PW'(in_data.a_re * in_data.b_im);
    m_brbr_r <= PW'(in_data.b_re * in_data.b_re);
    m_bibi_r <= PW'(in_data.b_im * in_data.b_im);
  end

  always_comb begin
    re_sum   = {p_arbr_r[PW-1], p_arbr_r} + {p_aibi_r[PW-1], p_aibi_r};
    im_sum   = {p_aibr_r[PW-1], p_aibr_r} - {p_arbi_r[PW-1], p_arbi_r};
    re_abs   = re_sum[PW] ? (~re_sum) + 1'b1 : re_sum;
    im_abs   = im_sum[PW] ? (~im_sum) + 1'b1 : im_sum;
    mag2     = {1'b0, m_brbr_r} + {1'b0, m_bibi_r};
    mag2_ext = DW'(mag2);
    eps_ext  = DW'(epsilon);
    below    = mag2_ext < eps_ext;
    if (below) begin
      den_nxt = clamp_mode ? eps_ext : '0;
    end else begin
      den_nxt = mag2_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    neg_re_r <= re_sum[PW];
    neg_im_r <= im_sum[PW];
    mag_re_r <= re_abs[PW-1:0];
    mag_im_r <= im_abs[PW-1:0];
    den2_r   <= den_nxt;
  end

  always_comb begin
    num_re_nxt = CW'(mag_re_r) << FRACTION_BITS;
    num_im_nxt = CW'(mag_im_r) << FRACTION_BITS;
    den_cw     = CW'(den2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= v2_r;
    end
    ctl_r.guard  <= den2_r == '0;
    ctl_r.neg_re <= neg_re_r;
    ctl_r.neg_im <= neg_im_r;
    ctl_r.ov_re  <= (num_re_nxt >> QW) >= den_cw;
    ctl_r.ov_im  <= (num_im_nxt >> QW) >= den_cw;
    num_re_r     <= num_re_nxt;
    num_im_r     <= num_im_nxt;
    den_r        <= den2_r;
  end

  assign ctl    = ctl_r;
  assign num_re = num_re_r;
  assign num_im = num_im_r;
  assign den    = den_r;

endmodule

@@ rtl/rcdiv_div_stage.sv @@
// ----------------------------------------------------------------------------
// rcdiv_div_stage
// One restoring division step: resolve one quotient bit for both parts.
// ----------------------------------------------------------------------------
module rcdiv_div_stage #(
  parameter int DW  = 33,
  parameter int CW  = 48,
  parameter int BIT = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rcdiv_pkg::ctl_t                     ctl_i,
  input  logic [CW-1:0]                       rem_re_i,
  input  logic [CW-1:0]                       rem_im_i,
  input  logic [rcdiv_pkg::QUOT_WIDTH-1:0]    q_re_i,
  input  logic [rcdiv_pkg::QUOT_WIDTH-1:0]    q_im_i,
  input  logic [DW-1:0]                       den_i,
  output rcdiv_pkg::ctl_t                     ctl_o,
  output logic [CW-1:0]                       rem_re_o,
  output logic [CW-1:0]                       rem_im_o,
  output logic [rcdiv_pkg::QUOT_WIDTH-1:0]    q_re_o,
  output logic [rcdiv_pkg::QUOT_WIDTH-1:0]    q_im_o,
  output logic [DW-1:0]                       den_o
);

  localparam int QW = rcdiv_pkg::QUOT_WIDTH;

  logic [CW-1:0]   den_ext, den_sh;
  logic            take_re, take_im;
  logic [CW-1:0]   rem_re_nxt, rem_im_nxt;
  logic [QW-1:0]   q_re_nxt, q_im_nxt;

  rcdiv_pkg::ctl_t ctl_r;
  logic [CW-1:0]   rem_re_r, rem_im_r;
  logic [QW-1:0]   q_re_r, q_im_r;
  logic [DW-1:0]   den_r;

  always_comb begin
    den_ext    = CW'(den_i);
    den_sh     = den_ext << BIT;
    take_re    = (rem_re_i >> BIT) >= den_ext;
    take_im    = (rem_im_i >> BIT) >= den_ext;
    rem_re_nxt = take_re ? rem_re_i - den_sh : rem_re_i;
    rem_im_nxt = take_im ? rem_im_i - den_sh : rem_im_i;
    q_re_nxt   = q_re_i | (QW'(take_re) << BIT);
    q_im_nxt   = q_im_i | (QW'(take_im) << BIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.guard  <= ctl_i.guard;
    ctl_r.neg_re <= ctl_i.neg_re;
    ctl_r.neg_im <= ctl_i.neg_im;
    ctl_r.ov_re  <= ctl_i.ov_re;
    ctl_r.ov_im  <= ctl_i.ov_im;
    rem_re_r     <= rem_re_nxt;
    rem_im_r     <= rem_im_nxt;
    q_re_r       <= q_re_nxt;
    q_im_r       <= q_im_nxt;
    den_r        <= den_i;
  end

  assign ctl_o    = ctl_r;
  assign rem_re_o = rem_re_r;
  assign rem_im_o = rem_im_r;
  assign q_re_o   = q_re_r;
  assign q_im_o   = q_im_r;
  assign den_o    = den_r;

endmodule

@@ rtl/rcdiv_back.sv @@
// ----------------------------------------------------------------------------
// rcdiv_back
// Saturation, sign restore and guard forcing of the quotient.
// ----------------------------------------------------------------------------
module rcdiv_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rcdiv_pkg::ctl_t                    ctl,
  input  logic [rcdiv_pkg::QUOT_WIDTH-1:0]   q_re,
  input  logic [rcdiv_pkg::QUOT_WIDTH-1:0]   q_im,
  output logic                               out_valid,
  output rcdiv_pkg::out_t                    out_data
);

  localparam int QW = rcdiv_pkg::QUOT_WIDTH;
  localparam logic [QW-1:0] POS_LIMIT = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIMIT = {1'b1, {(QW-1){1'b0}}};

  logic [QW-1:0]   lim_re, lim_im, qs_re, qs_im;
  logic            over_re, over_im;
  rcdiv_pkg::out_t res;
  logic            valid_r;
  rcdiv_pkg::out_t out_r;

  always_comb begin
    lim_re  = ctl.neg_re ? NEG_LIMIT : POS_LIMIT;
    lim_im  = ctl.neg_im ? NEG_LIMIT : POS_LIMIT;
    over_re = ctl.ov_re || (q_re > lim_re);
    over_im = ctl.ov_im || (q_im > lim_im);
    qs_re   = over_re ? lim_re : q_re;
    qs_im   = over_im ? lim_im : q_im;
    if (ctl.guard) begin
      res.q_re      = '0;
      res.q_im      = '0;
      res.guarded   = 1'b1;
      res.saturated = 1'b0;
    end else begin
      res.q_re      = ctl.neg_re ? (~qs_re) + 1'b1 : qs_re;
      res.q_im      = ctl.neg_im ? (~qs_im) + 1'b1 : qs_im;
      res.guarded   = 1'b0;
      res.saturated = over_re || over_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res;
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/regularized_complex_divider_core.sv @@
// ----------------------------------------------------------------------------
// regularized_complex_divider_core
// Pipelined pointwise complex division a / b with epsilon regularization,
// Q16.16 truncated and saturated quotient.
// ----------------------------------------------------------------------------
// Takes one sample pair every clock (busy stays low) and returns each result
// in order, as a one-cycle out_valid beat that cannot be held off. The
// pipeline is the restoring divider, one stage per quotient bit, preceded by
// three stages of products, sums and denominator select and followed by one
// stage of saturation. Configuration writes are always ready and take effect
// on items that start with or after the write.
// ----------------------------------------------------------------------------
module regularized_complex_divider_core #(
  parameter int FRACTION_BITS = rcdiv_pkg::FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  rcdiv_pkg::in_t                         in_data,
  output logic                                   out_valid,
  output rcdiv_pkg::out_t                        out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rcdiv_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [rcdiv_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  localparam int SW = rcdiv_pkg::SAMPLE_WIDTH;
  localparam int QW = rcdiv_pkg::QUOT_WIDTH;
  localparam int DW = (2 * SW + 1 > rcdiv_pkg::EPS_WIDTH) ? 2 * SW + 1 : rcdiv_pkg::EPS_WIDTH;
  localparam int NW = 2 * SW + FRACTION_BITS;
  localparam int CW = (NW > DW) ? NW : DW;

  logic [rcdiv_pkg::EPS_WIDTH-1:0] epsilon_r;
  logic                            clamp_mode_r;

  rcdiv_pkg::ctl_t ctl   [0:QW];
  logic [CW-1:0]   rem_re[0:QW];
  logic [CW-1:0]   rem_im[0:QW];
  logic [QW-1:0]   q_re  [0:QW];
  logic [QW-1:0]   q_im  [0:QW];
  logic [DW-1:0]   den   [0:QW];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epsilon_r    <= rcdiv_pkg::EPSILON_RESET;
      clamp_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rcdiv_pkg::CFG_EPSILON) begin
        epsilon_r <= cfg_data[rcdiv_pkg::EPS_WIDTH-1:0];
      end else if (cfg_index == rcdiv_pkg::CFG_CLAMP_MODE) begin
        clamp_mode_r <= cfg_data[0];
      end
    end
  end

  rcdiv_front #(
    .FRACTION_BITS(FRACTION_BITS),
    .DW           (DW),
    .CW           (CW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_data   (in_data),
    .epsilon   (epsilon_r),
    .clamp_mode(clamp_mode_r),
    .ctl       (ctl[0]),
    .num_re    (rem_re[0]),
    .num_im    (rem_im[0]),
    .den       (den[0])
  );

  assign q_re[0] = '0;
  assign q_im[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    rcdiv_div_stage #(
      .DW (DW),
      .CW (CW),
      .BIT(QW - 1 - k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[k]),
      .rem_re_i(rem_re[k]),
      .rem_im_i(rem_im[k]),
      .q_re_i  (q_re[k]),
      .q_im_i  (q_im[k]),
      .den_i   (den[k]),
      .ctl_o   (ctl[k+1]),
      .rem_re_o(rem_re[k+1]),
      .rem_im_o(rem_im[k+1]),
      .q_re_o  (q_re[k+1]),
      .q_im_o  (q_im[k+1]),
      .den_o   (den[k+1])
    );
  end

  rcdiv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl[QW]),
    .q_re     (q_re[QW]),
    .q_im     (q_im[QW]),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the regularized complex divider. A directed table
// runs at the reset settings, then randomized phases run across threshold
// and mode settings. Every beat is checked against the table entry where it
// gives one, else against an internal quotient predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import rcdiv_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED = 8'd5;
  localparam int PIPE_DEPTH = QUOT_WIDTH + 8;

  typedef struct {
    in_t  stim;
    bit   known;
    out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  logic [EPS_WIDTH-1:0] eps_q;
  logic                 clamp_q;
  out_t                 quot_fifo[$];
  int                   err_cnt;
  int                   beat_cnt;

  dir_row_t dir_tab [0:10] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0}},
    '{'{16'sd32767, -16'sd32768, 16'sd0, 16'sd0}, 1'b1,
      '{32'sd0, 32'sd0, 1'b1, 1'b0}},
    '{'{16'sd32767, 16'sd0, 16'sd1, 16'sd0}, 1'b1,
      '{32'sh7FFF0000, 32'sd0, 1'b0, 1'b0}},
    '{'{-16'sd32768, 16'sd0, 16'sd1, 16'sd0}, 1'b1,
      '{32'sh80000000, 32'sd0, 1'b0, 1'b0}},
    '{'{16'sd0, -16'sd32768, 16'sd1, 16'sd0}, 1'b1,
      '{32'sd0, 32'sh80000000, 1'b0, 1'b0}},
    '{'{16'sd1, 16'sd0, 16'sd2, 16'sd0}, 1'b1,
      '{32'sh00008000, 32'sd0, 1'b0, 1'b0}},
    '{'{-16'sd1, 16'sd0, 16'sd3, 16'sd0}, 1'b0, '{default: '0}},
    '{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768}, 1'b0, '{default: '0}},
    '{'{-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '{default: '0}},
    '{'{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1}, 1'b0, '{default: '0}},
    '{'{16'sd12345, -16'sd321, 16'sd1, 16'sd1}, 1'b0, '{default: '0}}
  };

  regularized_complex_divider_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [QUOT_WIDTH-1:0] quot_part(longint num, longint den,
                                                      inout bit sat);
    bit     neg;
    longint mag;
    longint q;
    longint limit;
    neg   = num < 0;
    mag   = neg ? -num : num;
    q     = (mag << FRACTION_BITS) / den;
    limit = neg ? 64'h80000000 : 64'h7FFFFFFF;
    if (q > limit) begin
      q   = limit;
      sat = 1'b1;
    end
    if (neg) q = -q;
    return q[QUOT_WIDTH-1:0];
  endfunction

  function automatic out_t divide_sample(in_t s);
    longint ar, ai, br, bi;
    longint mag2, den, eps;
    bit     sat;
    out_t   r;
    ar   = s.a_re;
    ai   = s.a_im;
    br   = s.b_re;
    bi   = s.b_im;
    eps  = {32'd0, eps_q};
    sat  = 1'b0;
    mag2 = br * br + bi * bi;
    if (clamp_q) den = (mag2 < eps) ? eps : mag2;
    else         den = (mag2 < eps) ? 0 : mag2;
    if (den == 0) begin
      r = '{32'sd0, 32'sd0, 1'b1, 1'b0};
    end else begin
      r.q_re      = quot_part(ar * br + ai * bi, den, sat);
      r.q_im      = quot_part(ai * br - ar * bi, den, sat);
      r.guarded   = 1'b0;
      r.saturated = sat;
    end
    return r;
  endfunction

  task automatic push_sample(in_t s, bit known, out_t want);
    while (!(beat_cnt >= 250 && beat_cnt < 350) && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (busy);
    quot_fifo.push_back(known ? want : divide_sample(s));
    beat_cnt++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (quot_fifo.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_EPSILON) eps_q = val;
    else if (idx == CFG_CLAMP_MODE) clamp_q = val[0];
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_b();
    int pick;
    pick = $urandom_range(7);
    if (pick < 2) return 16'($signed($urandom_range(8)) - 4);
    if (pick == 2) return $urandom_range(1) ? -16'sd32768 : 16'sd32767;
    return 16'($urandom);
  endfunction

  task automatic run_phase(logic [31:0] eps, logic mode, int n);
    in_t s;
    write_reg(CFG_EPSILON, eps);
    write_reg(CFG_CLAMP_MODE, {31'($urandom), mode});
    push_sample('{16'($urandom), 16'($urandom), 16'sd0, 16'sd0}, 1'b0, '0);
    push_sample('{16'($urandom), 16'($urandom), 16'sd1, 16'sd0}, 1'b0, '0);
    push_sample('{16'($urandom), 16'($urandom), -16'sd32768, -16'sd32768}, 1'b0, '0);
    repeat (n) begin
      s = '{16'($urandom), 16'($urandom), rand_b(), rand_b()};
      push_sample(s, 1'b0, '0);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (quot_fifo.size() == 0) begin
        $error("unexpected result beat q_re=%h", out_data.q_re);
        err_cnt++;
      end else begin
        out_t e;
        e = quot_fifo.pop_front();
        if (out_data.q_re !== e.q_re) begin
          $error("q_re expected %h actual %h", e.q_re, out_data.q_re);
          err_cnt++;
        end
        if (out_data.q_im !== e.q_im) begin
          $error("q_im expected %h actual %h", e.q_im, out_data.q_im);
          err_cnt++;
        end
        if (out_data.guarded !== e.guarded) begin
          $error("guarded expected %b actual %b", e.guarded, out_data.guarded);
          err_cnt++;
        end
        if (out_data.saturated !== e.saturated) begin
          $error("saturated expected %b actual %b", e.saturated, out_data.saturated);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    err_cnt   = 0;
    beat_cnt  = 0;
    eps_q     = EPSILON_RESET;
    clamp_q   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) push_sample(dir_tab[i].stim, dir_tab[i].known, dir_tab[i].want);
    drain();

    // ignore writes to an unmapped index
    write_reg(CFG_UNUSED, 32'h0);
    run_phase(32'd1, 1'b0, 8);
    run_phase(32'd0, 1'b0, 70);
    run_phase(32'd0, 1'b1, 70);
    run_phase(32'hFFFFFFFF, 1'b0, 40);
    run_phase(32'hFFFFFFFF, 1'b1, 70);
    run_phase(32'h80000000, 1'b1, 60);
    run_phase(32'h80000000, 1'b0, 40);
    run_phase($urandom_range(40), 1'b0, 80);
    run_phase($urandom_range(40), 1'b1, 80);
    run_phase($urandom, 1'($urandom_range(1)), 60);

    drain();
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
